// ===== hw/rtl/tpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpsc_pkg
// Shared types, register map and constants for the triggered ping-pong
// sample capture block.
// ----------------------------------------------------------------------------
package tpsc_pkg;

   // Largest buffer depth the design supports; the usable depth is also
   // capped by the 10-bit fill index.
   localparam int MAX_BUFFER_DEPTH = 1024;
   localparam int SIZE_CAP_INT     = (MAX_BUFFER_DEPTH < 1024) ? MAX_BUFFER_DEPTH : 1024;

   localparam int INDEX_W  = 10;
   localparam int SIZE_W   = 11;
   localparam int SAMPLE_W = 8;
   localparam int THRESH_W = 8;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(SIZE_CAP_INT);

   // Mid-scale of the unsigned sample range
   localparam logic [9:0] MID_SCALE = 10'h080;

   // Register reset values
   localparam logic                VAD_ENABLE_RST  = 1'b1;
   localparam logic [THRESH_W-1:0] THRESHOLD_RST   = 8'd64;
   localparam logic [SIZE_W-1:0]   BUFFER_SIZE_RST = 11'd1024;

   // Register indexes (byte address bits [3:2])
   typedef enum logic [1:0] {
      REG_VAD_ENABLE  = 2'd0,
      REG_THRESHOLD   = 2'd1,
      REG_BUFFER_SIZE = 2'd2,
      REG_UNUSED      = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_ACK    = 2'd1,
      CMD_START  = 2'd2,
      CMD_INIT   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic                vad_enable;
      logic [THRESH_W-1:0] threshold;
      logic [SIZE_W-1:0]   buffer_size;
   } cfg_type;

   typedef struct packed {
      logic                write_valid;
      logic                write_buffer;
      logic [INDEX_W-1:0]  write_index;
      logic [SAMPLE_W-1:0] write_data;
      logic                buffer_done;
      logic                done_buffer;
      logic                overflow;
      logic                is_triggered;
      logic                is_stopped;
   } rsp_type;

   // Clamp the programmed size into 1 .. SIZE_CAP
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] s;
      s = size;
      if (s == '0) begin
         s = SIZE_W'(1);
      end
      if (s > SIZE_CAP) begin
         s = SIZE_CAP;
      end
      return s;
   endfunction

endpackage

// ===== hw/rtl/triggered_pingpong_sample_capture.sv =====
// ----------------------------------------------------------------------------
// triggered_pingpong_sample_capture
// Level-triggered capture of 8-bit samples into two alternating buffers.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one command beat per handshake (cmd 0 sample, 1 acknowledge,
//            2 start capture, 3 re-arm trigger) with its sample.
//   rsp_*  : exactly one result beat per request beat, in order: the buffer
//            write to perform (buffer, index, data), the buffer-full report,
//            overflow and the trigger / stop status after the beat.
//   csr_*  : APB-style register port (0x0 vad_enable, 0x4 threshold,
//            0x8 buffer_size); pready is tied high. Write it only while idle.
// Timing: a request beat lands in the input register, and its result is
//   registered in the result register when the beat advances; it is offered
//   there until taken. One beat per cycle is sustained while rsp_ready stays
//   high; the single pass through the capture logic between the two
//   registers sets that figure.
// Stall: when rsp_ready is low the result register holds its beat, the input
//   register keeps one more, and req_ready drops once both are occupied.
// Reset: synchronous; clears both pipeline stages and the capture state
//   (untriggered, buffer 0, index 0) and restores the register defaults.
// ----------------------------------------------------------------------------
module triggered_pingpong_sample_capture (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_cmd,
   input  logic [tpsc_pkg::SAMPLE_W-1:0]  req_sample,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_write_valid,
   output logic                           rsp_write_buffer,
   output logic [tpsc_pkg::INDEX_W-1:0]   rsp_write_index,
   output logic [tpsc_pkg::SAMPLE_W-1:0]  rsp_write_data,
   output logic                           rsp_buffer_done,
   output logic                           rsp_done_buffer,
   output logic                           rsp_overflow,
   output logic                           rsp_is_triggered,
   output logic                           rsp_is_stopped,
   // register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tpsc_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [tpsc_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [tpsc_pkg::DATA_W-1:0]    csr_prdata,
   output logic                           csr_pready
);
   import tpsc_pkg::*;

   cfg_type             cfg;

   // input register
   logic                s1_valid_ff, s1_valid_in;
   cmd_type             s1_cmd_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_next;

   logic                out_free;
   logic                s1_fire;
   logic                req_fire;

   tpsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Result register frees up when empty or when its beat is taken this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // Advance the input register into the result register
   assign s1_fire   = s1_valid_ff && out_free;
   // Accept a new beat whenever the input register empties this cycle
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   // Capture state commits only when the beat actually moves on
   tpsc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (s1_fire),
      .cmd    (s1_cmd_ff),
      .sample (s1_sample_ff),
      .cfg    (cfg),
      .rsp    (rsp_next)
   );

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff    <= cmd_type'(req_cmd);
         s1_sample_ff <= req_sample;
      end
      if (s1_fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_valid  = rsp_ff.write_valid;
   assign rsp_write_buffer = rsp_ff.write_buffer;
   assign rsp_write_index  = rsp_ff.write_index;
   assign rsp_write_data   = rsp_ff.write_data;
   assign rsp_buffer_done  = rsp_ff.buffer_done;
   assign rsp_done_buffer  = rsp_ff.done_buffer;
   assign rsp_overflow     = rsp_ff.overflow;
   assign rsp_is_triggered = rsp_ff.is_triggered;
   assign rsp_is_stopped   = rsp_ff.is_stopped;

endmodule

// ===== hw/rtl/tpsc_csr.sv =====
// ----------------------------------------------------------------------------
// tpsc_csr
// APB-style register file: trigger enable, threshold and buffer size.
// ----------------------------------------------------------------------------
module tpsc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [tpsc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [tpsc_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [tpsc_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready,
   output tpsc_pkg::cfg_type            cfg
);
   import tpsc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_VAD_ENABLE:  cfg_in.vad_enable  = csr_pwdata[0];
            REG_THRESHOLD:   cfg_in.threshold   = csr_pwdata[THRESH_W-1:0];
            REG_BUFFER_SIZE: cfg_in.buffer_size = csr_pwdata[SIZE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_VAD_ENABLE:  csr_prdata = DATA_W'(cfg_ff.vad_enable);
         REG_THRESHOLD:   csr_prdata = DATA_W'(cfg_ff.threshold);
         REG_BUFFER_SIZE: csr_prdata = DATA_W'(cfg_ff.buffer_size);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vad_enable  <= VAD_ENABLE_RST;
         cfg_ff.threshold   <= THRESHOLD_RST;
         cfg_ff.buffer_size <= BUFFER_SIZE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/tpsc_core.sv =====
// ----------------------------------------------------------------------------
// tpsc_core
// Capture state and per-beat decision: trigger detect, write position,
// buffer switch and overflow.
// ----------------------------------------------------------------------------
module tpsc_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  tpsc_pkg::cmd_type              cmd,
   input  logic [tpsc_pkg::SAMPLE_W-1:0]  sample,
   input  tpsc_pkg::cfg_type              cfg,
   output tpsc_pkg::rsp_type              rsp
);
   import tpsc_pkg::*;

   logic               triggered_ff, triggered_in;
   logic               active_buf_ff, active_buf_in;
   logic [INDEX_W-1:0] fill_index_ff, fill_index_in;
   logic               full_pending_ff, full_pending_in;
   logic               halted_ff, halted_in;

   logic [SIZE_W-1:0]  next_count;
   logic [9:0]         smp_plus_t;
   logic [9:0]         mid_plus_t;
   logic               out_of_window;

   assign next_count    = SIZE_W'(fill_index_ff) + SIZE_W'(1);
   // s < 128 - t  <=>  s + t < 128 ;  s > 128 + t
   assign smp_plus_t    = 10'(sample) + 10'(cfg.threshold);
   assign mid_plus_t    = MID_SCALE + 10'(cfg.threshold);
   assign out_of_window = (smp_plus_t < MID_SCALE) || (10'(sample) > mid_plus_t);

   always_comb begin
      triggered_in    = triggered_ff;
      active_buf_in   = active_buf_ff;
      fill_index_in   = fill_index_ff;
      full_pending_in = full_pending_ff;
      halted_in       = halted_ff;
      rsp             = '0;

      case (cmd)
         CMD_SAMPLE: begin
            if (!halted_ff) begin
               if (triggered_ff) begin
                  rsp.write_valid  = 1'b1;
                  rsp.write_buffer = active_buf_ff;
                  rsp.write_index  = fill_index_ff;
                  rsp.write_data   = sample;
                  if (next_count >= eff_size(cfg.buffer_size)) begin
                     if (full_pending_ff) begin
                        rsp.overflow = 1'b1;
                        halted_in    = 1'b1;
                     end else begin
                        full_pending_in  = 1'b1;
                        rsp.buffer_done  = 1'b1;
                        rsp.done_buffer  = active_buf_ff;
                        active_buf_in    = ~active_buf_ff;
                        fill_index_in    = '0;
                     end
                  end else begin
                     fill_index_in = next_count[INDEX_W-1:0];
                  end
               end else if (out_of_window) begin
                  triggered_in = 1'b1;
               end
            end
         end
         CMD_ACK: begin
            full_pending_in = 1'b0;
         end
         CMD_START: begin
            active_buf_in   = 1'b0;
            fill_index_in   = '0;
            full_pending_in = 1'b0;
            halted_in       = 1'b0;
         end
         default: begin
            triggered_in  = ~cfg.vad_enable;
            active_buf_in = 1'b0;
            fill_index_in = '0;
         end
      endcase

      rsp.is_triggered = triggered_in;
      rsp.is_stopped   = halted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         triggered_ff    <= 1'b0;
         active_buf_ff   <= 1'b0;
         fill_index_ff   <= '0;
         full_pending_ff <= 1'b0;
         halted_ff       <= 1'b0;
      end else if (step) begin
         triggered_ff    <= triggered_in;
         active_buf_ff   <= active_buf_in;
         fill_index_ff   <= fill_index_in;
         full_pending_ff <= full_pending_in;
         halted_ff       <= halted_in;
      end
   end

endmodule

// ===== hw/rtl/tpsc_checker.sv =====
// ----------------------------------------------------------------------------
// tpsc_checker
// Port-level checks for the capture block, bound to the top level.
// ----------------------------------------------------------------------------
module tpsc_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_write_valid,
   input  logic [tpsc_pkg::INDEX_W-1:0]   rsp_write_index,
   input  logic [tpsc_pkg::SAMPLE_W-1:0]  rsp_write_data,
   input  logic                           rsp_buffer_done,
   input  logic                           rsp_overflow,
   input  logic                           rsp_is_triggered,
   input  logic                           rsp_is_stopped
);
   import tpsc_pkg::*;

   // Result beat holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_index)
         && $stable(rsp_write_data) && $stable(rsp_buffer_done))
      else $error("result beat changed while stalled");

   // A full report only comes with a write while triggered
   a_done_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_buffer_done |-> rsp_write_valid && rsp_is_triggered
         && !rsp_overflow)
      else $error("buffer report without a triggered write");

   // Overflow writes the last sample and stops capture
   a_overflow_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_is_stopped && rsp_write_valid)
      else $error("overflow without stop or write");

   // No write means no write position, data or report
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_valid |-> rsp_write_index == '0
         && rsp_write_data == '0 && !rsp_buffer_done && !rsp_overflow)
      else $error("write fields set without a write");

   // Reset empties the result channel
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind triggered_pingpong_sample_capture tpsc_checker u_tpsc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_write_valid  (rsp_write_valid),
   .rsp_write_index  (rsp_write_index),
   .rsp_write_data   (rsp_write_data),
   .rsp_buffer_done  (rsp_buffer_done),
   .rsp_overflow     (rsp_overflow),
   .rsp_is_triggered (rsp_is_triggered),
   .rsp_is_stopped   (rsp_is_stopped)
);
